// ===== rtl/fault_formation_heightmap_defines.svh =====
// Assertion macros used by the height map back end.
// Needs clk and arst_n in scope where used.
`ifndef FAULT_FORMATION_HEIGHTMAP_DEFINES_SVH
`define FAULT_FORMATION_HEIGHTMAP_DEFINES_SVH

// same-cycle implication
`define FFH_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define FFH_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/ffh_pkg.sv =====
// Types and constants for the fault formation height map.
// No dependencies.
package ffh_pkg;
	localparam int MAX_GRID = 256;
	localparam int CW       = $clog2(MAX_GRID);
	localparam int AW       = 2 * CW;
	localparam int DEPTH    = MAX_GRID * MAX_GRID;
	localparam int NW       = CW + 1;
	localparam int HW       = 32;

	typedef enum logic [1:0] {
		CMD_CLEAR  = 2'd0,
		CMD_FAULT  = 2'd1,
		CMD_SMOOTH = 2'd2,
		CMD_READ   = 2'd3
	} cmd_t;

	localparam logic REG_GRID_SIZE     = 1'b0;
	localparam logic REG_SMOOTH_WEIGHT = 1'b1;

	typedef struct packed {
		cmd_t               cmd;
		logic [7:0]         ax;
		logic [7:0]         az;
		logic [7:0]         bx;
		logic [7:0]         bz;
		logic signed [23:0] h;
		logic               bad;
		logic [NW-1:0]      n;
		logic [8:0]         w;
	} ffh_item_t;

	typedef struct packed {
		logic      valid;
		ffh_item_t item;
	} ffh_head_t;

	typedef struct packed {
		logic init_busy;
		logic pop;
	} ffh_back_ctl_t;
endpackage

// ===== rtl/fault_formation_heightmap.sv =====
// Top level of the fault formation height map.
// Depends on ffh_pkg, ffh_front and ffh_back.
//
// Requests enter on in_valid/in_stall with command and point/height fields;
// each request gives exactly one result on out_valid/out_stall.
// Registers grid_size (0x0) and smooth_weight (0x4) sit on the APB port;
// the user must write them only while the block is idle, which the block
// itself does not enforce. The back end works on one map cell per cycle,
// set by the single map RAM port pair: clear sweeps all 65536 cells, fault
// the n*n cells of a map of side n, smooth them in four passes, and read
// a single cell; a rejected fault or read goes straight to its result.
// A two-entry queue holds further requests while the back end works.
// After reset the map is zeroed by a clearing pass over all 65536 cells,
// during which in_stall stays high; configuration writes are taken as ever.
// If the receiver stalls, the result is held and the back end takes no new
// request until it is gone; the queue keeps accepting until full.
module fault_formation_heightmap import ffh_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         command,
	input  logic [7:0]         point_a_x,
	input  logic [7:0]         point_a_z,
	input  logic [7:0]         point_b_x,
	input  logic [7:0]         point_b_z,
	input  logic signed [23:0] fault_height,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] height_value,
	output logic               status
);
	ffh_head_t     head;
	ffh_back_ctl_t ctl;

	ffh_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.command      (command),
		.point_a_x    (point_a_x),
		.point_a_z    (point_a_z),
		.point_b_x    (point_b_x),
		.point_b_z    (point_b_z),
		.fault_height (fault_height),
		.ctl          (ctl),
		.head         (head)
	);

	ffh_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (head),
		.ctl          (ctl),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.height_value (height_value),
		.status       (status)
	);
endmodule

// ===== rtl/ffh_ram.sv =====
// Generic single write, single read RAM with registered read data.
// No dependencies.
module ffh_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

// ===== rtl/ffh_front.sv =====
// Front end: APB registers, request classification and a two-entry queue.
// Depends on ffh_pkg.
module ffh_front import ffh_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         command,
	input  logic [7:0]         point_a_x,
	input  logic [7:0]         point_a_z,
	input  logic [7:0]         point_b_x,
	input  logic [7:0]         point_b_z,
	input  logic signed [23:0] fault_height,
	input  ffh_back_ctl_t      ctl,
	output ffh_head_t          head
);
	logic [8:0]    grid_size_q;
	logic [8:0]    smooth_weight_q;
	ffh_item_t     entry_q [2];
	logic          wr_ptr_q;
	logic          rd_ptr_q;
	logic [1:0]    count_q;
	ffh_item_t     item;
	logic [NW-1:0] n;
	logic          push;

	assign pready = 1'b1;

	always_comb begin
		case (paddr[2])
			REG_GRID_SIZE: prdata = {23'd0, grid_size_q};
			default:       prdata = {23'd0, smooth_weight_q};
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_size_q     <= 9'd256;
			smooth_weight_q <= 9'd128;
		end else if (psel && penable && pwrite) begin
			case (paddr[2])
				REG_GRID_SIZE: grid_size_q     <= pwdata[8:0];
				default:       smooth_weight_q <= pwdata[8:0];
			endcase
		end
	end

	always_comb begin
		if (grid_size_q < 9'd2) begin
			n = NW'(2);
		end else if (32'(grid_size_q) > MAX_GRID) begin
			n = NW'(MAX_GRID);
		end else begin
			n = NW'(grid_size_q);
		end
		item.cmd = cmd_t'(command);
		item.ax  = point_a_x;
		item.az  = point_a_z;
		item.bx  = point_b_x;
		item.bz  = point_b_z;
		item.h   = fault_height;
		item.n   = n;
		item.w   = (smooth_weight_q > 9'd256) ? 9'd256 : smooth_weight_q;
		unique case (cmd_t'(command))
			CMD_FAULT: item.bad = (NW'(point_a_x) >= n) || (NW'(point_a_z) >= n) ||
				(NW'(point_b_x) >= n) || (NW'(point_b_z) >= n);
			CMD_READ:  item.bad = (NW'(point_a_x) >= n) || (NW'(point_a_z) >= n);
			default:   item.bad = 1'b0;
		endcase
	end

	assign in_stall = (count_q == 2'd2) || ctl.init_busy;
	assign push     = in_valid && !in_stall;

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (ctl.pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			count_q <= count_q + 2'(push) - 2'(ctl.pop);
		end
	end

	assign head.valid = (count_q != 2'd0);
	assign head.item  = entry_q[rd_ptr_q];
endmodule

// ===== rtl/ffh_back.sv =====
// Back end: map sweeps for clear, fault, smooth and read, plus result register.
// Depends on ffh_pkg, ffh_ram and the assertion macros header.
`include "fault_formation_heightmap_defines.svh"
module ffh_back import ffh_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  ffh_head_t          head,
	output ffh_back_ctl_t      ctl,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] height_value,
	output logic               status
);
	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_CLEAR = 6'b000010,
		ST_SCAN  = 6'b000100,
		ST_DRAIN = 6'b001000,
		ST_READ  = 6'b010000,
		ST_RESP  = 6'b100000
	} state_t;

	state_t               state_q;
	ffh_item_t            item_q;
	logic                 init_q;
	logic [AW-1:0]        clr_q;
	logic [1:0]           pass_q;
	logic [NW-1:0]        i_q;
	logic [NW-1:0]        k_q;
	logic                 stat_q;
	logic                 out_valid_q;
	logic signed [31:0]   value_q;
	logic signed [31:0]   prev_q;
	logic                 valid_s1;
	logic                 first_s1;
	logic                 raise_s1;
	logic [AW-1:0]        addr_s1;

	logic [NW-1:0]        last;
	logic [NW-1:0]        kr;
	logic [NW-1:0]        cx;
	logic [NW-1:0]        cz;
	logic [AW-1:0]        scan_addr;
	logic signed [NW:0]   rx;
	logic signed [NW:0]   rz;
	logic signed [8:0]    dx;
	logic signed [8:0]    dz;
	logic signed [NW+10:0] cp;
	logic                 we;
	logic [AW-1:0]        waddr;
	logic [AW-1:0]        raddr;
	logic signed [31:0]   wdata;
	logic signed [31:0]   rdata;
	logic signed [32:0]   fsum;
	logic signed [31:0]   fsat;
	logic signed [32:0]   diff;
	logic signed [42:0]   blend_s;
	logic signed [31:0]   blended;
	logic                 take;

	ffh_ram #(.WIDTH(HW), .DEPTH(DEPTH)) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	assign take          = (state_q == ST_IDLE) && head.valid && !out_valid_q;
	assign ctl.pop       = take;
	assign ctl.init_busy = init_q;

	always_comb begin
		last = item_q.n - NW'(1);
		kr   = pass_q[0] ? (last - k_q) : k_q;
		cx   = pass_q[1] ? i_q : kr;
		cz   = pass_q[1] ? kr : i_q;
		scan_addr = {cz[CW-1:0], cx[CW-1:0]};
		rx = $signed({1'b0, cx}) - $signed({1'b0, NW'(item_q.ax)});
		rz = $signed({1'b0, cz}) - $signed({1'b0, NW'(item_q.az)});
		dx = $signed({1'b0, item_q.bx}) - $signed({1'b0, item_q.ax});
		dz = $signed({1'b0, item_q.bz}) - $signed({1'b0, item_q.az});
		cp = (NW+11)'(rx) * (NW+11)'(dz) - (NW+11)'(dx) * (NW+11)'(rz);
	end

	always_comb begin
		fsum = {rdata[31], rdata} + 33'(item_q.h);
		if (fsum[32] != fsum[31]) begin
			fsat = fsum[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
		end else begin
			fsat = fsum[31:0];
		end
		diff    = {prev_q[31], prev_q} - {rdata[31], rdata};
		blend_s = $signed({{3{rdata[31]}}, rdata, 8'd0}) +
			43'($signed({1'b0, item_q.w})) * 43'(diff) + 43'sd128;
		blended = blend_s[39:8];
	end

	always_comb begin
		raddr = (state_q == ST_READ) ? {CW'(item_q.az), CW'(item_q.ax)} : scan_addr;
		if (state_q == ST_CLEAR) begin
			we    = 1'b1;
			waddr = clr_q;
			wdata = '0;
		end else begin
			waddr = addr_s1;
			if (item_q.cmd == CMD_FAULT) begin
				we    = valid_s1 && raise_s1;
				wdata = fsat;
			end else begin
				we    = valid_s1 && !first_s1;
				wdata = blended;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_q <= head.item;
		end
		addr_s1  <= scan_addr;
		first_s1 <= (k_q == '0);
		raise_s1 <= (cp > 0);
		if (valid_s1) begin
			prev_q <= first_s1 ? rdata : blended;
		end
		if (state_q == ST_RESP) begin
			value_q <= (item_q.cmd == CMD_READ && !stat_q) ? rdata : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			init_q      <= 1'b1;
			clr_q       <= '0;
			pass_q      <= '0;
			i_q         <= '0;
			k_q         <= '0;
			stat_q      <= 1'b0;
			out_valid_q <= 1'b0;
			valid_s1    <= 1'b0;
		end else begin
			valid_s1 <= (state_q == ST_SCAN);
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (take) begin
						stat_q <= head.item.bad;
						pass_q <= '0;
						i_q    <= '0;
						k_q    <= '0;
						clr_q  <= '0;
						if (head.item.bad) begin
							state_q <= ST_RESP;
						end else begin
							unique case (head.item.cmd)
								CMD_CLEAR: state_q <= ST_CLEAR;
								CMD_READ:  state_q <= ST_READ;
								default:   state_q <= ST_SCAN;
							endcase
						end
					end
				end
				ST_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == '1) begin
						init_q  <= 1'b0;
						state_q <= init_q ? ST_IDLE : ST_RESP;
					end
				end
				ST_SCAN: begin
					if (k_q == last) begin
						k_q <= '0;
						if (i_q == last) begin
							state_q <= ST_DRAIN;
						end else begin
							i_q <= i_q + NW'(1);
						end
					end else begin
						k_q <= k_q + NW'(1);
					end
				end
				ST_DRAIN: begin
					i_q <= '0;
					if (item_q.cmd == CMD_FAULT || pass_q == 2'd3) begin
						state_q <= ST_RESP;
					end else begin
						pass_q  <= pass_q + 2'd1;
						state_q <= ST_SCAN;
					end
				end
				ST_READ: state_q <= ST_RESP;
				ST_RESP: begin
					out_valid_q <= 1'b1;
					state_q     <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid    = out_valid_q;
	assign height_value = value_q;
	assign status       = stat_q;

	`FFH_ASSERT_NOW(a_no_result_in_init, init_q, !out_valid_q, "result during reset clear")
	`FFH_ASSERT_NOW(a_pop_when_free, ctl.pop, (state_q == ST_IDLE) && !out_valid_q, "bad pop")
	`FFH_ASSERT_NEXT(a_drain_empties, state_q == ST_DRAIN, !valid_s1, "drain left work")
	`FFH_ASSERT_NEXT(a_resp_gives_result, state_q == ST_RESP, out_valid_q, "result lost")
endmodule
